### hdl/tlsch_pkg.sv
// Shared types and constants for the TLS ClientHello checker.
`timescale 1ns / 1ps

package tlsch_pkg;

	localparam logic [7:0]  HELLO_TYPE  = 8'd1;
	localparam logic [15:0] VERSION_12  = 16'h0303;
	localparam logic [15:0] SUITE_RESET = 16'hC02F;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

	// Byte offsets inside the message, type byte at zero.
	localparam int unsigned MIN_LEN     = 39;
	localparam int unsigned RANDOM_LAST = 37;
	localparam int unsigned SESSION_POS = 38;

	localparam int unsigned RANDOM_W = 256;
	localparam int unsigned WORD_W   = 64;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_SHORT       = 3'd1,
		ST_LENGTH      = 3'd2,
		ST_VERSION     = 3'd3,
		ST_NO_LIST_LEN = 3'd4,
		ST_BAD_LIST    = 3'd5,
		ST_NO_SUITE    = 3'd6
	} status_t;

	typedef logic [1:0] word_idx_t;

	// Verdict handed from the parser to the result emitter.
	typedef struct packed {
		status_t               status;
		logic [15:0]           suite;
		logic [RANDOM_W-1:0]   random;
	} verdict_t;

endpackage

### hdl/tlsch_if.sv
// Channel interfaces: message bytes, configuration writes and result items.
`timescale 1ns / 1ps

interface tlsch_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
	modport mon    (input valid, ready, data_byte, last_byte);
endinterface

interface tlsch_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
	modport mon    (input valid, ready, data);
endinterface

interface tlsch_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] chosen_suite;
	logic [63:0] random_word;
	logic [1:0]  word_index;
	logic        last_result;

	modport source (output valid, status, chosen_suite, random_word, word_index, last_result,
		input ready);
	modport sink   (input valid, status, chosen_suite, random_word, word_index, last_result,
		output ready);
	modport mon    (input valid, ready, status, chosen_suite, random_word, word_index,
		last_result);
endinterface

### hdl/tlsch_front.sv
// Byte parser: records header fields, scans cipher suites, judges on the last byte.
`timescale 1ns / 1ps

module tlsch_front (
	input  logic               clk,
	input  logic               arst_n,
	tlsch_in_if.sink           hello,
	tlsch_cfg_if.sink          cfg,
	output logic               push,
	output tlsch_pkg::verdict_t push_data,
	input  logic               full
);
	import tlsch_pkg::*;

	logic [15:0]         wanted_q;
	logic [15:0]         count_q;
	logic [7:0]          type_q,    type_n;
	logic [23:0]         body_q,    body_n;
	logic [15:0]         version_q, version_n;
	logic [RANDOM_W-1:0] random_q,  random_n;
	logic [7:0]          session_q, session_n;
	logic [15:0]         list_q,    list_n;
	logic [7:0]          high_q,    high_n;
	logic                seen_q,    seen_n;

	logic        accept;
	logic        over;
	logic [15:0] start;
	logic [15:0] off;
	logic [15:0] k;
	logic [16:0] n;
	logic [24:0] len_total;
	logic [8:0]  pos;
	logic [17:0] list_end;
	status_t     status;

	assign cfg.ready   = 1'b1;
	assign hello.ready = !full;
	assign accept      = hello.valid && !full;
	assign over        = (count_q == COUNT_MAX);

	assign start = 16'(MIN_LEN) + {8'h00, session_q};
	assign off   = count_q - start;
	assign k     = off - 16'd2;

	// Field capture for the byte at position count_q
	always_comb begin
		type_n    = type_q;
		body_n    = body_q;
		version_n = version_q;
		random_n  = random_q;
		session_n = session_q;
		list_n    = list_q;
		high_n    = high_q;
		seen_n    = seen_q;
		if (!over) begin
			priority if (count_q == 16'd0) begin
				type_n = hello.data_byte;
			end else if (count_q <= 16'd3) begin
				body_n = {body_q[15:0], hello.data_byte};
			end else if (count_q <= 16'd5) begin
				version_n = {version_q[7:0], hello.data_byte};
			end else if (count_q <= 16'(RANDOM_LAST)) begin
				random_n = {random_q[RANDOM_W-9:0], hello.data_byte};
			end else if (count_q == 16'(SESSION_POS)) begin
				session_n = hello.data_byte;
			end else begin
				// Session id bytes pass through untouched
				if (count_q >= start) begin
					priority if (off == 16'd0) begin
						list_n = {hello.data_byte, 8'h00};
					end else if (off == 16'd1) begin
						list_n = list_q | {8'h00, hello.data_byte};
					end else begin
						if (k < list_q) begin
							if (!k[0]) begin
								high_n = hello.data_byte;
							end else if ({high_q, hello.data_byte} == wanted_q) begin
								seen_n = 1'b1;
							end
						end
					end
				end
			end
		end
	end

	// Checks in priority order, on the updated fields
	assign n         = {1'b0, count_q} + 17'd1;
	assign len_total = {1'b0, body_n} + 25'd4;
	assign pos       = 9'(MIN_LEN) + {1'b0, session_n};
	assign list_end  = {9'h000, pos} + 18'd3 + {2'b00, list_n};

	always_comb begin
		priority if (n < 17'(MIN_LEN) || type_n != HELLO_TYPE) begin
			status = ST_SHORT;
		end else if (over || len_total != {8'h00, n}) begin
			status = ST_LENGTH;
		end else if (version_n != VERSION_12) begin
			status = ST_VERSION;
		end else if (({8'h00, pos} + 17'd2) > n) begin
			status = ST_NO_LIST_LEN;
		end else if (list_n[0] || list_end > {1'b0, n}) begin
			status = ST_BAD_LIST;
		end else if (!seen_n) begin
			status = ST_NO_SUITE;
		end else begin
			status = ST_OK;
		end
	end

	assign push             = accept && hello.last_byte;
	assign push_data.status = status;
	assign push_data.suite  = wanted_q;
	assign push_data.random = random_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= SUITE_RESET;
		end else if (cfg.valid) begin
			wanted_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			type_q    <= '0;
			body_q    <= '0;
			version_q <= '0;
			session_q <= '0;
			list_q    <= '0;
			high_q    <= '0;
			seen_q    <= 1'b0;
		end else if (accept) begin
			if (hello.last_byte) begin
				// Message done: clear per-message fields
				count_q   <= '0;
				type_q    <= '0;
				body_q    <= '0;
				version_q <= '0;
				session_q <= '0;
				list_q    <= '0;
				high_q    <= '0;
				seen_q    <= 1'b0;
			end else begin
				count_q   <= over ? count_q : count_q + 16'd1;
				type_q    <= type_n;
				body_q    <= body_n;
				version_q <= version_n;
				session_q <= session_n;
				list_q    <= list_n;
				high_q    <= high_n;
				seen_q    <= seen_n;
			end
		end
	end

	// Random bytes are all rewritten before any success reads them
	always_ff @(posedge clk) begin
		if (accept) begin
			random_q <= random_n;
		end
	end

endmodule

### hdl/tlsch_queue.sv
// Short verdict queue between the parser and the result emitter.
`timescale 1ns / 1ps

module tlsch_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tlsch_pkg::verdict_t push_data,
	output logic                full,
	output logic                head_valid,
	output tlsch_pkg::verdict_t head_data,
	input  logic                pop
);
	import tlsch_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	verdict_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hdl/tlsch_back.sv
// Result emitter: one item per error verdict, four random words per success.
`timescale 1ns / 1ps

module tlsch_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  tlsch_pkg::verdict_t head_data,
	output logic                pop,
	tlsch_out_if.source         result
);
	import tlsch_pkg::*;

	logic              valid_q;
	word_idx_t         idx_q;
	logic [2:0]        status_q;
	logic [15:0]       suite_q;
	logic [WORD_W-1:0] word_q;
	word_idx_t         index_q;
	logic              last_q;

	logic              advance;
	logic              ok;
	logic              item_last;
	logic [WORD_W-1:0] slice;

	assign advance   = !valid_q || result.ready;
	assign ok        = (head_data.status == ST_OK);
	assign item_last = !ok || (idx_q == 2'd3);
	assign pop       = advance && head_valid && item_last;

	// First random byte sits in the top word
	always_comb begin
		unique case (idx_q)
			2'd0:    slice = head_data.random[4*WORD_W-1:3*WORD_W];
			2'd1:    slice = head_data.random[3*WORD_W-1:2*WORD_W];
			2'd2:    slice = head_data.random[2*WORD_W-1:WORD_W];
			default: slice = head_data.random[WORD_W-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= item_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			status_q <= head_data.status;
			suite_q  <= ok ? head_data.suite : 16'h0000;
			word_q   <= ok ? slice : '0;
			index_q  <= ok ? idx_q : 2'd0;
			last_q   <= item_last;
		end
	end

	assign result.valid        = valid_q;
	assign result.status       = status_q;
	assign result.chosen_suite = suite_q;
	assign result.random_word  = word_q;
	assign result.word_index   = index_q;
	assign result.last_result  = last_q;

endmodule

### hdl/tls_client_hello_checker.sv
// Top level of the TLS 1.2 ClientHello checker.
//
// Usage:
//   hello  - message bytes, type byte first, last_byte marks the final byte.
//            One byte is taken per cycle; ready drops only while the verdict
//            queue is full.
//   cfg    - write of the wanted cipher suite (reset 0xC02F); always ready.
//            Write only while no message is in flight and all results are out.
//   result - one transfer per error (status, other fields zero, last_result
//            set) or four transfers on success, word_index 0..3, each with the
//            suite and eight random bytes, last_result on the fourth.
// Path: the final byte's verdict enters the verdict queue, and the first result
//   is then loaded from the queue head into the output register. The parser
//   takes one byte per cycle while the queue is not full, and the emitter moves
//   one result per cycle out of its output register while result.ready is high.
// Stall: when result.ready is low, the output register holds and verdicts
//   collect in a QUEUE_DEPTH deep queue; the parser keeps taking bytes until
//   the queue fills on a final byte.
// Reset: arst_n clears the parser fields other than the random bytes, the queue
//   and output valid, and loads the reset suite. No clearing pass is needed.
`timescale 1ns / 1ps

module tls_client_hello_checker #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	tlsch_in_if.sink    hello,
	tlsch_cfg_if.sink   cfg,
	tlsch_out_if.source result
);
	import tlsch_pkg::*;

	logic     push;
	verdict_t push_data;
	logic     full;
	logic     head_valid;
	verdict_t head_data;
	logic     pop;

	// Parse bytes and judge each message on its final byte
	tlsch_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hello     (hello),
		.cfg       (cfg),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Decouple parsing from result delivery
	tlsch_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop)
	);

	// Expand each verdict into its result transfers
	tlsch_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.result     (result)
	);

endmodule

### hdl/tlsch_checker.sv
// Port-level assertions for the ClientHello checker, bound to the top level.
`timescale 1ns / 1ps

module tlsch_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  logic        ready,
	input  logic [2:0]  status,
	input  logic [15:0] chosen_suite,
	input  logic [63:0] random_word,
	input  logic [1:0]  word_index,
	input  logic        last_result
);
	import tlsch_pkg::*;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=>
			valid && $stable(status) && $stable(random_word)
			&& $stable(word_index) && $stable(last_result))
		else $error("stalled result changed");

	// An error result stands alone with empty fields
	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != ST_OK |->
			last_result && chosen_suite == 16'h0000
			&& random_word == 64'h0 && word_index == 2'd0)
		else $error("malformed error result");

	// Success ends exactly on the fourth word
	a_ok_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status == ST_OK |->
			last_result == (word_index == 2'd3))
		else $error("success last flag misplaced");

	// Success words follow each other without a gap
	a_ok_seq: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready && status == ST_OK && !last_result |=>
			valid && status == ST_OK
			&& word_index == $past(word_index) + 2'd1)
		else $error("success words out of sequence");

endmodule

bind tls_client_hello_checker tlsch_checker u_tlsch_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (result.valid),
	.ready        (result.ready),
	.status       (result.status),
	.chosen_suite (result.chosen_suite),
	.random_word  (result.random_word),
	.word_index   (result.word_index),
	.last_result  (result.last_result)
);

### test/tb_top.sv
// Self-checking testbench for the TLS ClientHello checker: byte stream in, verdicts out.
`timescale 1ns / 1ps

import tlsch_pkg::*;

typedef struct {
	status_t     status;
	logic [15:0] suite;
	logic [63:0] word;
	logic [1:0]  index;
	logic        last;
} hello_result_t;

class hello_scoreboard;
	logic [15:0]   wanted;
	logic [15:0]   seen_count;
	logic [7:0]    hs_type;
	logic [23:0]   body_len;
	logic [15:0]   ver;
	logic [63:0]   rand_words [4];
	logic [7:0]    sid_len;
	logic [15:0]   cipher_len;
	logic [7:0]    pair_high;
	bit            suite_hit;
	hello_result_t due_results [$];
	int unsigned   fails;

	function new();
		wanted = SUITE_RESET;
		fails = 0;
		restart_message();
	endfunction

	function void restart_message();
		seen_count = '0;
		hs_type = '0;
		body_len = '0;
		ver = '0;
		for (int i = 0; i < 4; i++) rand_words[i] = '0;
		sid_len = '0;
		cipher_len = '0;
		pair_high = '0;
		suite_hit = 0;
	endfunction

	function int unsigned pending();
		return due_results.size();
	endfunction

	// Record one byte at position b of the message.
	function void record_field(int unsigned b, logic [7:0] v);
		int unsigned w, start, off, k;
		if (b == 0) begin
			hs_type = v;
		end else if (b <= 3) begin
			body_len = {body_len[15:0], v};
		end else if (b <= 5) begin
			ver = {ver[7:0], v};
		end else if (b <= RANDOM_LAST) begin
			w = ((b - 6) >> 3) & 3;
			rand_words[w] = {rand_words[w][55:0], v};
		end else if (b == SESSION_POS) begin
			sid_len = v;
		end else begin
			start = MIN_LEN + sid_len;
			if (b < start) return;
			off = b - start;
			if (off == 0) begin
				cipher_len = {v, 8'h00};
			end else if (off == 1) begin
				cipher_len = cipher_len | {8'h00, v};
			end else begin
				k = off - 2;
				if (k < cipher_len) begin
					if ((k & 1) == 0) begin
						pair_high = v;
					end else if ({pair_high, v} == wanted) begin
						suite_hit = 1;
					end
				end
			end
		end
	endfunction

	// Note one accepted byte; on the final byte, queue the verdict it causes.
	function void absorb_byte(logic [7:0] v, bit last);
		bit            over;
		int unsigned   n, pos;
		status_t       st;
		hello_result_t r;
		over = (seen_count == COUNT_MAX);
		if (!over) record_field(int'(seen_count), v);
		n = over ? 65536 : int'(seen_count) + 1;
		if (!over) seen_count = seen_count + 16'd1;
		if (!last) return;
		pos = MIN_LEN + sid_len;
		if (n < MIN_LEN || hs_type != HELLO_TYPE) st = ST_SHORT;
		else if (over || 4 + body_len != n) st = ST_LENGTH;
		else if (ver != VERSION_12) st = ST_VERSION;
		else if (pos + 2 > n) st = ST_NO_LIST_LEN;
		else if (cipher_len[0] || pos + 3 + cipher_len > n) st = ST_BAD_LIST;
		else if (!suite_hit) st = ST_NO_SUITE;
		else st = ST_OK;
		if (st != ST_OK) begin
			r.status = st;
			r.suite = '0;
			r.word = '0;
			r.index = '0;
			r.last = 1'b1;
			due_results.push_back(r);
		end else begin
			for (int i = 0; i < 4; i++) begin
				r.status = ST_OK;
				r.suite = wanted;
				r.word = rand_words[i];
				r.index = 2'(i);
				r.last = (i == 3);
				due_results.push_back(r);
			end
		end
		restart_message();
	endfunction

	function void check_result(hello_result_t got);
		hello_result_t exp;
		if (due_results.size() == 0) begin
			$error("unexpected result: status %0d index %0d", got.status, got.index);
			fails++;
			return;
		end
		exp = due_results.pop_front();
		if (got.status !== exp.status) begin
			$error("status: expected %0d, got %0d", exp.status, got.status);
			fails++;
		end
		if (got.suite !== exp.suite) begin
			$error("chosen_suite: expected %04h, got %04h", exp.suite, got.suite);
			fails++;
		end
		if (got.word !== exp.word) begin
			$error("random_word: expected %016h, got %016h", exp.word, got.word);
			fails++;
		end
		if (got.index !== exp.index) begin
			$error("word_index: expected %0d, got %0d", exp.index, got.index);
			fails++;
		end
		if (got.last !== exp.last) begin
			$error("last_result: expected %0b, got %0b", exp.last, got.last);
			fails++;
		end
	endfunction
endclass

module tb_top;

	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	// Settling time after the last expected result has drained.
	localparam int unsigned SETTLE_CYCLES  = 4;

	typedef enum int {
		FLAW_NONE,
		FLAW_NO_SUITE,
		FLAW_TYPE,
		FLAW_LENGTH,
		FLAW_VERSION,
		FLAW_SHORT,
		FLAW_NO_LIST,
		FLAW_LIST_ODD,
		FLAW_LIST_OVER,
		FLAW_OUTSIDE,
		FLAW_NOISE
	} flaw_t;

	logic clk;
	logic arst_n;

	tlsch_in_if  hello_ch ();
	tlsch_cfg_if cfg_ch ();
	tlsch_out_if result_ch ();

	tls_client_hello_checker u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.hello  (hello_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	hello_scoreboard sb;

	// Message under construction, type byte first.
	logic [7:0]  msg [$];
	logic [15:0] wanted_now;
	int unsigned gap_pct;
	bit          hold_off_req;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// Message construction
	// ---------------------------------------------------------------

	// Rewrite the 24-bit body length to match the message as it stands.
	function automatic void set_body_length();
		int unsigned len;
		len = msg.size() - 4;
		msg[1] = len[23:16];
		msg[2] = len[15:8];
		msg[3] = len[7:0];
	endfunction

	// Build a well-formed hello; when offer is set, one list pair is the wanted suite
	// and every other pair differs from it.
	function automatic void build_hello(int unsigned sid_n, int unsigned pairs, bit offer,
		int unsigned tail_n);
		int unsigned slot, list_bytes;
		logic [15:0] s;
		msg.delete();
		msg.push_back(HELLO_TYPE);
		repeat (3) msg.push_back(8'h00);
		msg.push_back(VERSION_12[15:8]);
		msg.push_back(VERSION_12[7:0]);
		repeat (32) msg.push_back(8'($urandom));
		msg.push_back(8'(sid_n));
		repeat (sid_n) msg.push_back(8'($urandom));
		list_bytes = pairs * 2;
		msg.push_back(list_bytes[15:8]);
		msg.push_back(list_bytes[7:0]);
		slot = (offer && pairs != 0) ? $urandom_range(0, pairs - 1) : pairs;
		for (int unsigned i = 0; i < pairs; i++) begin
			s = 16'($urandom);
			if (s == wanted_now) s = ~s;
			if (i == slot) s = wanted_now;
			msg.push_back(s[15:8]);
			msg.push_back(s[7:0]);
		end
		repeat (tail_n) msg.push_back(8'($urandom));
		set_body_length();
	endfunction

	function automatic void build_noise(int unsigned max_len);
		msg.delete();
		repeat ($urandom_range(1, max_len)) msg.push_back(8'($urandom));
	endfunction

	// Damage a well-formed hello so that it trips one particular check.
	function automatic void apply_flaw(flaw_t f);
		int unsigned list_at, list_bytes, tail_n, cut;
		logic [23:0] body;
		list_at = MIN_LEN + msg[SESSION_POS];
		case (f)
			FLAW_TYPE: begin
				msg[0] = 8'($urandom);
				if (msg[0] == HELLO_TYPE) msg[0] = 8'hFE;
			end
			FLAW_LENGTH: begin
				body = {msg[1], msg[2], msg[3]};
				if ($urandom_range(0, 1) == 0) body = body + 24'($urandom_range(1, 3));
				else body = body ^ 24'($urandom_range(1, 24'hFFFFFF));
				msg[1] = body[23:16];
				msg[2] = body[15:8];
				msg[3] = body[7:0];
			end
			FLAW_VERSION: begin
				do begin
					msg[4] = ($urandom_range(0, 1) == 0) ? 8'h03 : 8'($urandom);
					msg[5] = 8'($urandom);
				end while ({msg[4], msg[5]} == VERSION_12);
			end
			FLAW_SHORT: begin
				cut = $urandom_range(1, MIN_LEN - 1);
				while (msg.size() > cut) void'(msg.pop_back());
			end
			FLAW_NO_LIST: begin
				// Stop before the list length has both of its bytes.
				cut = list_at + $urandom_range(0, 1);
				while (msg.size() > cut) void'(msg.pop_back());
				set_body_length();
			end
			FLAW_LIST_ODD: begin
				msg[list_at + 1] = msg[list_at + 1] | 8'h01;
			end
			FLAW_LIST_OVER: begin
				list_bytes = {msg[list_at], msg[list_at + 1]};
				tail_n = msg.size() - (list_at + 2 + list_bytes);
				list_bytes = (list_bytes + tail_n + $urandom_range(0, 20) + 1) & ~32'd1;
				if (list_bytes > 65534) list_bytes = 65534;
				msg[list_at] = list_bytes[15:8];
				msg[list_at + 1] = list_bytes[7:0];
			end
			FLAW_OUTSIDE: begin
				// Offer the suite only past the end of the list.
				msg[msg.size() - 2] = wanted_now[15:8];
				msg[msg.size() - 1] = wanted_now[7:0];
			end
			FLAW_NOISE: build_noise(80);
			default: ;
		endcase
	endfunction

	function automatic void make_random_message();
		flaw_t       f;
		int unsigned sid_n, pairs, tail_n;
		f = ($urandom_range(0, 19) < 11) ? FLAW_NONE : flaw_t'($urandom_range(1, FLAW_NOISE));
		sid_n = $urandom_range(0, 8);
		pairs = $urandom_range(1, 4);
		tail_n = $urandom_range(2, 4);
		build_hello(sid_n, pairs, f != FLAW_NO_SUITE && f != FLAW_OUTSIDE, tail_n);
		apply_flaw(f);
	endfunction

	// ---------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------

	// Offer one byte after an optional gap and hold it until its transfer.
	task automatic send_byte(logic [7:0] v, bit last);
		int unsigned g;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
			hello_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		hello_ch.valid <= 1'b1;
		hello_ch.data_byte <= v;
		hello_ch.last_byte <= last;
		do @(posedge clk); while (hello_ch.ready !== 1'b1);
		sb.absorb_byte(v, last);
	endtask

	task automatic send_message();
		foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
	endtask

	// Drop valid, let every expected result drain, then let the parser settle.
	task automatic wait_idle();
		hello_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the wanted suite; call only after wait_idle.
	task automatic write_suite(logic [15:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		sb.wanted = v;
		wanted_now = v;
	endtask

	task automatic send_flawed(int unsigned sid_n, int unsigned pairs, bit offer,
		int unsigned tail_n, flaw_t f);
		build_hello(sid_n, pairs, offer, tail_n);
		apply_flaw(f);
		send_message();
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		sb = new();
		wanted_now = SUITE_RESET;
		gap_pct = 10;
		hold_off_req = 1'b0;
		arst_n <= 1'b0;
		hello_ch.valid <= 1'b0;
		hello_ch.data_byte <= '0;
		hello_ch.last_byte <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, still on the reset suite: a short passing hello first.
		send_flawed(0, 1, 1, 1, FLAW_NONE);
		// A lone marked byte is the shortest possible message.
		msg.delete();
		msg.push_back(8'hFF);
		send_message();
		send_flawed(0, 1, 1, 1, FLAW_SHORT);
		send_flawed(0, 1, 1, 1, FLAW_LENGTH);
		send_flawed(0, 1, 1, 1, FLAW_VERSION);
		send_flawed(0, 1, 1, 1, FLAW_NO_LIST);
		send_flawed(1, 1, 1, 1, FLAW_LIST_ODD);

		// Extremes of the suite register.
		wait_idle();
		write_suite(16'h0000);
		send_flawed(0, 1, 1, 1, FLAW_NONE);
		wait_idle();
		write_suite(16'hFFFF);
		send_flawed(0, 1, 0, 2, FLAW_OUTSIDE);

		// Back-pressure: the receiver holds off for a long stretch while short
		// messages keep coming, so the verdict queue fills and input stalls.
		wait_idle();
		hold_off_req = 1'b1;
		gap_pct = 0;
		repeat (8) begin
			build_noise(3);
			send_message();
		end
		// Pause the sender until every verdict has drained.
		wait_idle();

		// Random part with a fresh suite.
		write_suite(16'($urandom));
		gap_pct = 15;
		make_random_message();
		send_message();

		wait_idle();
		repeat (16) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("PASS tls_client_hello_checker");
		else
			$display("FAIL tls_client_hello_checker");
		$finish;
	end

	// ---------------------------------------------------------------
	// Result sink: check each transfer and vary ready. Switch between free-running
	// stretches and stretches of random stalls; honor a long hold-off on request.
	// ---------------------------------------------------------------
	initial begin
		hello_result_t got;
		int unsigned   hold_left, mode_left;
		bit            free_run;
		hold_left = 0;
		mode_left = 0;
		free_run = 1'b0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				got.status = status_t'(result_ch.status);
				got.suite = result_ch.chosen_suite;
				got.word = result_ch.random_word;
				got.index = result_ch.word_index;
				got.last = result_ch.last_result;
				sb.check_result(got);
			end
			if (mode_left == 0) begin
				free_run = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			if (hold_off_req) begin
				hold_left = LONG_HOLD;
				hold_off_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (free_run) begin
				result_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 30) begin
				hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25)
					: $urandom_range(0, 2);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: count cycles with no transfer on any channel.
	// ---------------------------------------------------------------
	initial begin
		int unsigned quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((hello_ch.valid === 1'b1 && hello_ch.ready === 1'b1)
				|| (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
				|| (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL tls_client_hello_checker");
		$finish;
	end

endmodule

### tls_client_hello_checker.f
hdl/tlsch_pkg.sv
hdl/tlsch_if.sv
hdl/tlsch_front.sv
hdl/tlsch_queue.sv
hdl/tlsch_back.sv
hdl/tls_client_hello_checker.sv
hdl/tlsch_checker.sv
test/tb_top.sv
